// ----- hdl/mma_pkg.sv -----
package mma_pkg;

  // Field widths of the stream and configuration ports
  localparam int CMD_W = 3;
  localparam int OPD_W = 64;
  localparam int RES_W = 31;
  localparam int CFG_W = 31;

  // Modulus width kept in hardware (8..31)
  localparam int MOD_BITS = 31;
  localparam int MCNT_W   = $clog2(MOD_BITS);
  localparam int RCNT_W   = $clog2(OPD_W);

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(31'd998244353);

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POW = 3'd4;

  // Request to the shared modular add/subtract unit; operands not above the modulus, sum below twice it
  typedef struct packed {
    logic                sub;
    logic [MOD_BITS-1:0] p;
    logic [MOD_BITS-1:0] q;
  } unit_req_t;

  function automatic logic [OPD_W-1:0] abs64(input logic [OPD_W-1:0] v);
    return v[OPD_W-1] ? (OPD_W'(0) - v) : v;
  endfunction

endpackage

// ----- hdl/mma_addsub.sv -----
module mma_addsub (
  input  mma_pkg::unit_req_t          req,
  input  logic [mma_pkg::MOD_BITS-1:0] m,
  output logic [mma_pkg::MOD_BITS-1:0] y
);

  logic [mma_pkg::MOD_BITS:0] sum;
  logic [mma_pkg::MOD_BITS:0] dif;

  always_comb begin
    sum = {1'b0, req.p} + {1'b0, req.q};
    dif = {1'b0, req.p} - {1'b0, req.q};
    if (req.sub) begin
      // borrow: wrap up by the modulus
      if (dif[mma_pkg::MOD_BITS]) begin
        y = dif[mma_pkg::MOD_BITS-1:0] + m;
      end else begin
        y = dif[mma_pkg::MOD_BITS-1:0];
      end
    end else begin
      if (sum >= {1'b0, m}) begin
        y = mma_pkg::MOD_BITS'(sum - {1'b0, m});
      end else begin
        y = sum[mma_pkg::MOD_BITS-1:0];
      end
    end
  end

endmodule

// ----- hdl/mma_core.sv -----
module mma_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mma_pkg::MOD_BITS-1:0]  m,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mma_pkg::CMD_W-1:0]     command,
  input  logic [mma_pkg::OPD_W-1:0]     operand_a,
  input  logic [mma_pkg::OPD_W-1:0]     operand_b,
  output logic                          fin,
  input  logic                          take,
  output logic [mma_pkg::MOD_BITS-1:0]  res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_FIX   = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_SUB   = 4'd4;
  localparam logic [3:0] S_PSTEP = 4'd5;
  localparam logic [3:0] S_MDBL  = 4'd6;
  localparam logic [3:0] S_MADD  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic [1:0] K_RES = 2'd0;
  localparam logic [1:0] K_ACC = 2'd1;
  localparam logic [1:0] K_SQR = 2'd2;

  localparam int MB = mma_pkg::MOD_BITS;
  localparam int OW = mma_pkg::OPD_W;

  logic [3:0]                     state;
  logic [mma_pkg::CMD_W-1:0]      cmd;
  logic                           phase_b;
  logic                           neg;
  logic [OW-1:0]                  mag;
  logic [OW-1:0]                  opb;
  logic [mma_pkg::RCNT_W-1:0]     cnt_r;
  logic [MB-1:0]                  r;
  logic [MB-1:0]                  ra;
  logic [OW-1:0]                  e;
  logic [MB-1:0]                  acc;
  logic [MB-1:0]                  base;
  logic [MB-1:0]                  mx;
  logic [MB-1:0]                  my;
  logic [MB-1:0]                  macc;
  logic [mma_pkg::MCNT_W-1:0]     cnt_m;
  logic [1:0]                     mkind;

  mma_pkg::unit_req_t             req;
  logic [MB-1:0]                  uy;
  logic [MB-1:0]                  rv;
  logic                           m_one;
  logic                           m_small;

  mma_addsub u_addsub (
    .req (req),
    .m   (m),
    .y   (uy)
  );

  assign in_ready = (state == S_IDLE);
  assign fin      = (state == S_FIN);
  assign rv       = neg ? uy : r;
  assign m_one    = (m == MB'(1));
  assign m_small  = (m[MB-1:1] == '0);

  always_comb begin
    req.sub = 1'b0;
    req.p   = '0;
    req.q   = '0;
    case (state)
      S_RED: begin
        req.p = r;
        req.q = r + MB'(mag[cnt_r]);
      end
      S_FIX: begin
        req.sub = 1'b1;
        req.q   = r;
      end
      S_ADD: begin
        req.p = ra;
        req.q = base;
      end
      S_SUB: begin
        req.sub = 1'b1;
        req.p   = ra;
        req.q   = base;
      end
      S_MDBL: begin
        req.p = macc;
        req.q = macc;
      end
      S_MADD: begin
        req.p = macc;
        req.q = mx;
      end
      default: begin
        req.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd     <= command;
            opb     <= operand_b;
            mag     <= mma_pkg::abs64(operand_a);
            neg     <= operand_a[OW-1];
            r       <= '0;
            cnt_r   <= mma_pkg::RCNT_W'(OW - 1);
            phase_b <= 1'b0;
            if (m == '0) begin
              res   <= '0;
              state <= S_FIN;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          // shift in one magnitude bit, keep remainder below the modulus
          r <= uy;
          if (cnt_r == '0) begin
            state <= S_FIX;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_FIX: begin
          if (!phase_b) begin
            ra <= rv;
            if (cmd == mma_pkg::CMD_POW) begin
              e     <= mma_pkg::abs64(opb);
              acc   <= m_one ? MB'(0) : MB'(1);
              base  <= rv;
              state <= S_PSTEP;
            end else if (cmd == mma_pkg::CMD_ADD || cmd == mma_pkg::CMD_SUB ||
                         cmd == mma_pkg::CMD_MUL || cmd == mma_pkg::CMD_DIV) begin
              mag     <= mma_pkg::abs64(opb);
              neg     <= opb[OW-1];
              r       <= '0;
              cnt_r   <= mma_pkg::RCNT_W'(OW - 1);
              phase_b <= 1'b1;
              state   <= S_RED;
            end else begin
              res   <= '0;
              state <= S_FIN;
            end
          end else begin
            // base holds the reduced second operand for add and subtract
            base <= rv;
            case (cmd)
              mma_pkg::CMD_ADD: state <= S_ADD;
              mma_pkg::CMD_SUB: state <= S_SUB;
              mma_pkg::CMD_MUL: begin
                mx    <= ra;
                my    <= rv;
                macc  <= '0;
                cnt_m <= mma_pkg::MCNT_W'(MB - 1);
                mkind <= K_RES;
                state <= S_MDBL;
              end
              mma_pkg::CMD_DIV: begin
                if (rv == '0 || m_small) begin
                  res   <= '0;
                  state <= S_FIN;
                end else begin
                  e     <= OW'(m) - OW'(2);
                  acc   <= MB'(1);
                  state <= S_PSTEP;
                end
              end
              default: begin
                res   <= '0;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_ADD: begin
          res   <= uy;
          state <= S_FIN;
        end
        S_SUB: begin
          res   <= uy;
          state <= S_FIN;
        end
        S_PSTEP: begin
          if (e == '0) begin
            if (cmd == mma_pkg::CMD_POW) begin
              res   <= acc;
              state <= S_FIN;
            end else begin
              // divide: dividend times inverse
              mx    <= ra;
              my    <= acc;
              macc  <= '0;
              cnt_m <= mma_pkg::MCNT_W'(MB - 1);
              mkind <= K_RES;
              state <= S_MDBL;
            end
          end else if (e[0]) begin
            e     <= {e[OW-1:1], 1'b0};
            mx    <= acc;
            my    <= base;
            macc  <= '0;
            cnt_m <= mma_pkg::MCNT_W'(MB - 1);
            mkind <= K_ACC;
            state <= S_MDBL;
          end else begin
            e <= {1'b0, e[OW-1:1]};
            if (e[OW-1:1] != '0) begin
              mx    <= base;
              my    <= base;
              macc  <= '0;
              cnt_m <= mma_pkg::MCNT_W'(MB - 1);
              mkind <= K_SQR;
              state <= S_MDBL;
            end
          end
        end
        S_MDBL: begin
          macc <= uy;
          if (my[cnt_m]) begin
            state <= S_MADD;
          end else if (cnt_m != '0) begin
            cnt_m <= cnt_m - 1'b1;
          end else begin
            case (mkind)
              K_ACC: begin
                acc   <= uy;
                state <= S_PSTEP;
              end
              K_SQR: begin
                base  <= uy;
                state <= S_PSTEP;
              end
              default: begin
                res   <= uy;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_MADD: begin
          macc <= uy;
          if (cnt_m != '0) begin
            cnt_m <= cnt_m - 1'b1;
            state <= S_MDBL;
          end else begin
            case (mkind)
              K_ACC: begin
                acc   <= uy;
                state <= S_PSTEP;
              end
              K_SQR: begin
                base  <= uy;
                state <= S_PSTEP;
              end
              default: begin
                res   <= uy;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/modular_arithmetic_alu.sv -----
// Modular add, subtract, multiply, divide and power over a modulus held in
// cfg_wdata's register (reset 998244353). Both operands are reduced first,
// negatives wrapped upward; power takes operand_b's magnitude as exponent and
// divide multiplies by the divisor to the power modulus-2, so the modulus must be
// prime for divide (a divisor that is a multiple of the modulus gives 0). One
// request is worked at a time through a single modular add/subtract unit: each
// operand reduction takes one operand bit per cycle, and each modular multiply
// is bit-serial, double and add. The time of divide and power is set by the
// count of bit-serial multiplies in square-and-multiply.
// The result register lets the next request enter while a result waits.
module modular_arithmetic_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata,      // modulus
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // command[2:0], operand_a[66:3], operand_b[130:67]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // result_value[30:0]
);

  localparam int MB = mma_pkg::MOD_BITS;
  localparam int CW = mma_pkg::CMD_W;
  localparam int OW = mma_pkg::OPD_W;

  logic [MB-1:0] modulus;
  logic          fin;
  logic          take;
  logic [MB-1:0] res;
  logic [mma_pkg::RES_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mma_pkg::MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata[MB-1:0];
    end
  end

  mma_core u_core (
    .clk       (clk),
    .rst       (rst),
    .m         (modulus),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .command   (s_axis_tdata[CW-1:0]),
    .operand_a (s_axis_tdata[CW+OW-1:CW]),
    .operand_b (s_axis_tdata[CW+2*OW-1:CW+OW]),
    .fin       (fin),
    .take      (take),
    .res       (res)
  );

  // load the output register when empty or being drained
  assign take = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin && take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && take) begin
      out_value <= mma_pkg::RES_W'(res);
    end
  end

  assign m_axis_tdata = {1'b0, out_value};

endmodule

// ----- tb/testbench.sv -----
module testbench;

  localparam logic [mma_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [mma_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [mma_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int QUIET_LIMIT = 50000;
  localparam int N_DIR = 22;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [mma_pkg::CMD_W-1:0] op;
    logic [63:0]               a;
    logic [63:0]               b;
    logic                      pinned;   // want is typed in, not predicted
    logic [mma_pkg::RES_W-1:0] want;
  } alu_row_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [30:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;    // command[2:0], operand_a[66:3], operand_b[130:67]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;    // result_value[30:0]

  logic [63:0]               mod_now;
  logic [mma_pkg::RES_W-1:0] pending_results[$];
  bit                        idle_bursts;
  int                        n_fail;
  int                        n_req;
  int                        n_res;
  int                        n_moduli;
  int                        quiet;

  // Directed rows, all under the reset modulus 998244353
  alu_row_t dir_rows [N_DIR] = '{
    '{mma_pkg::CMD_ADD, 64'd0, 64'd0, 1'b1, 31'd0},
    '{mma_pkg::CMD_ADD, -64'sd1, 64'd0, 1'b1, 31'd998244352},
    '{mma_pkg::CMD_SUB, 64'd0, 64'd1, 1'b1, 31'd998244352},
    '{mma_pkg::CMD_SUB, MIN64, MIN64, 1'b1, 31'd0},
    '{mma_pkg::CMD_ADD, MIN64, MAX64, 1'b0, 31'd0},
    '{mma_pkg::CMD_MUL, MAX64, MAX64, 1'b0, 31'd0},
    '{mma_pkg::CMD_MUL, MIN64, -64'sd1, 1'b0, 31'd0},
    '{mma_pkg::CMD_MUL, 64'd998244352, 64'd998244352, 1'b1, 31'd1},
    '{mma_pkg::CMD_DIV, 64'd5, 64'd0, 1'b1, 31'd0},
    '{mma_pkg::CMD_DIV, 64'd7, 64'd998244353, 1'b1, 31'd0},
    '{mma_pkg::CMD_DIV, 64'd1, -64'sd998244353, 1'b1, 31'd0},
    '{mma_pkg::CMD_DIV, 64'd1, 64'd2, 1'b0, 31'd0},
    '{mma_pkg::CMD_DIV, MAX64, MIN64, 1'b0, 31'd0},
    '{mma_pkg::CMD_POW, 64'd12345, 64'd0, 1'b1, 31'd1},
    '{mma_pkg::CMD_POW, 64'd0, 64'd0, 1'b1, 31'd1},
    '{mma_pkg::CMD_POW, 64'd3, 64'd5, 1'b1, 31'd243},
    '{mma_pkg::CMD_POW, 64'd3, -64'sd5, 1'b1, 31'd243},
    '{mma_pkg::CMD_POW, -64'sd2, -64'sd1, 1'b1, 31'd998244351},
    '{mma_pkg::CMD_POW, 64'd2, MAX64, 1'b0, 31'd0},
    '{mma_pkg::CMD_POW, 64'd7, MIN64, 1'b0, 31'd0},
    '{CMD_RSVD5, MAX64, MAX64, 1'b1, 31'd0},
    '{CMD_RSVD6, 64'd1, 64'd1, 1'b1, 31'd0}
  };

  modular_arithmetic_alu i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Wrap a signed 64-bit operand into 0..m-1
  function automatic logic [63:0] wrap_operand(input logic [63:0] raw, input logic [63:0] m);
    logic [63:0] rem;
    if (raw[63]) begin
      rem = (64'd0 - raw) % m;
      return (rem == 64'd0) ? 64'd0 : m - rem;
    end
    return raw % m;
  endfunction

  function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y,
                                              input logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mod_product(acc, base, m);
      base = mod_product(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [mma_pkg::RES_W-1:0] modular_result(
      input logic [mma_pkg::CMD_W-1:0] op,
      input logic [63:0]               a_raw,
      input logic [63:0]               b_raw);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    m = mod_now;
    if (m == 64'd0) return '0;
    a = wrap_operand(a_raw, m);
    b = wrap_operand(b_raw, m);
    case (op)
      mma_pkg::CMD_ADD: r = (a + b) % m;
      mma_pkg::CMD_SUB: r = (a >= b) ? a - b : a + m - b;
      mma_pkg::CMD_MUL: r = mod_product(a, b, m);
      mma_pkg::CMD_DIV: r = (b == 64'd0 || m < 64'd2) ? 64'd0 :
                            mod_product(a, mod_power(b, m - 64'd2, m), m);
      // exponent is the magnitude of operand_b, never reduced
      mma_pkg::CMD_POW: r = mod_power(a, b_raw[63] ? 64'd0 - b_raw : b_raw, m);
      default: r = 64'd0;
    endcase
    return r[mma_pkg::RES_W-1:0];
  endfunction

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 3));
      1: v = 64'd0 - 64'($urandom_range(1, 3));
      2: begin
        v = mod_now * 64'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) v = 64'd0 - v;
        if ($urandom_range(0, 2) == 0) v = v + 64'd1;
      end
      3: v = MIN64;
      4: v = MAX64;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pick_exponent();
    logic [63:0] e;
    case ($urandom_range(0, 7))
      0: e = {$urandom, $urandom};
      1: e = 64'd0 - 64'($urandom_range(0, 40));
      default: e = 64'($urandom_range(0, 40));
    endcase
    return e;
  endfunction

  // Present one request, hold it until accepted, then log its expected result
  task automatic send_request(input logic [mma_pkg::CMD_W-1:0] op, input logic [63:0] a,
                              input logic [63:0] b, input logic pinned,
                              input logic [mma_pkg::RES_W-1:0] want);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, b, a, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(pinned ? want : modular_result(op, a, b));
    n_req++;
  endtask

  // Change the modulus once every pending result is out
  task automatic load_modulus(input logic [30:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    mod_now = 64'(mma_pkg::MOD_BITS'(value));
    n_moduli++;
  endtask

  task automatic run_batch(input int count);
    logic [mma_pkg::CMD_W-1:0] op;
    logic [63:0]               a;
    logic [63:0]               b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0)
        op = mma_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      else
        op = mma_pkg::CMD_W'($urandom_range(mma_pkg::CMD_ADD, mma_pkg::CMD_POW));
      a  = pick_operand();
      b  = (op == mma_pkg::CMD_POW) ? pick_exponent() : pick_operand();
      send_request(op, a, b, 1'b0, '0);
    end
  endtask

  // Result side: random stall bursts on tready
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_bursts && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 m_axis_tdata[mma_pkg::RES_W-1:0]);
        n_fail++;
      end else if (m_axis_tdata[mma_pkg::RES_W-1:0] !== pending_results[0]) begin
        $display("%0t: result_value mismatch, expected %0d, actual %0d", $time,
                 pending_results[0], m_axis_tdata[mma_pkg::RES_W-1:0]);
        n_fail++;
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog: end the run when no request and no result moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_bursts   = 1'b1;
    mod_now       = 64'(mma_pkg::MOD_RESET);
    n_fail        = 0;
    n_req         = 0;
    n_res         = 0;
    n_moduli      = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].pinned,
                   dir_rows[i].want);

    // Degenerate moduli: everything comes out 0
    load_modulus(31'd1);
    send_request(mma_pkg::CMD_POW, 64'd5, 64'd0, 1'b1, 31'd0);
    send_request(mma_pkg::CMD_SUB, 64'd0, 64'd1, 1'b1, 31'd0);
    send_request(mma_pkg::CMD_DIV, 64'd3, 64'd4, 1'b1, 31'd0);
    load_modulus(31'd0);
    send_request(mma_pkg::CMD_POW, 64'd5, 64'd0, 1'b1, 31'd0);
    send_request(mma_pkg::CMD_ADD, MAX64, 64'd9, 1'b1, 31'd0);
    send_request(mma_pkg::CMD_DIV, 64'd3, 64'd4, 1'b1, 31'd0);

    load_modulus(31'd2);
    run_batch(18);
    load_modulus(31'd7);
    run_batch(18);
    load_modulus(31'h7FFF_FFFF);
    run_batch(20);
    load_modulus(31'd65537);
    run_batch(18);
    load_modulus(31'($urandom_range(2, 32'h7FFF_FFFF)));
    run_batch(18);
    load_modulus(31'h7FFF_FFFF);
    run_batch(10);
    load_modulus(31'd998244353);
    idle_bursts = 1'b0;
    run_batch(18);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d moduli,", n_req, n_res, n_moduli);
    $display("including zero and unit moduli and 64-bit operand and exponent extremes.");
    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
